// File: rtl/rs485m_pkg.sv
// Shared types, codes and defaults for the RS485 nine-bit master transaction block.
package rs485m_pkg;

   localparam int LENGTH_BITS_DEF  = 8;
   localparam int TIMEOUT_BITS_DEF = 16;

   // Address mark carried in bit 8 of a line word.
   localparam logic [8:0] NINTH_BIT_MASK = 9'h100;

   typedef enum logic [2:0] {
      ACT_START    = 3'd0,
      ACT_TX_EMPTY = 3'd1,
      ACT_TX_DONE  = 3'd2,
      ACT_RX_BYTE  = 3'd3,
      ACT_OVERRUN  = 3'd4,
      ACT_TICK     = 3'd5,
      ACT_ABORT    = 3'd6
   } action_type;

   typedef enum logic [2:0] {
      ERR_NONE    = 3'd0,
      ERR_OVERRUN = 3'd1,
      ERR_TIMEOUT = 3'd2,
      ERR_SYNC    = 3'd3,
      ERR_ABORT   = 3'd4
   } error_type;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'b001,
      PHASE_SEND = 3'b010,
      PHASE_RECV = 3'b100
   } phase_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [8:0]  data_word;
      logic [7:0]  request_length;
      logic [7:0]  response_length;
      logic [15:0] timeout_ticks;
      logic        set_ninth_bit;
      logic        expected_ninth_bit;
   } req_type;

   typedef struct packed {
      logic       start_accepted;
      logic       busy_res;
      logic       drive_enable;
      logic       tx_valid;
      logic [8:0] tx_word;
      logic       rx_valid;
      logic [7:0] rx_byte;
      logic       done_res;
      logic [2:0] error_code;
   } rsp_type;

endpackage

// File: rtl/rs485m_if.sv
// Valid/ready channel interfaces for the request and response streams.
interface rs485m_req_if;
   import rs485m_pkg::*;

   logic    valid;
   logic    ready;
   req_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

interface rs485m_rsp_if;
   import rs485m_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source(output valid, output payload, input ready);
   modport sink(input valid, input payload, output ready);
endinterface

// File: rtl/rs485m_seq.sv
// Transaction state and the per-event next-state and result logic.
module rs485m_seq #(
   parameter int LENGTH_BITS  = rs485m_pkg::LENGTH_BITS_DEF,
   parameter int TIMEOUT_BITS = rs485m_pkg::TIMEOUT_BITS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  rs485m_pkg::req_type item,
   output rs485m_pkg::rsp_type result
);
   import rs485m_pkg::*;

   phase_type               phase_ff, phase_in;
   logic [LENGTH_BITS-1:0]  remaining_ff, remaining_in;
   logic [TIMEOUT_BITS-1:0] ticks_ff, ticks_in;
   logic [LENGTH_BITS-1:0]  resp_len_ff, resp_len_in;
   logic [TIMEOUT_BITS-1:0] timeout_ff, timeout_in;
   logic                    exp_bit_ff, exp_bit_in;

   logic [7:0]              req_len_m1;
   logic [31:0]             req_len_wide;
   logic [31:0]             resp_len_wide;
   logic [31:0]             timeout_wide;
   logic [LENGTH_BITS-1:0]  remaining_dec;
   logic                    finish;
   error_type               err;

   // Fixed-width start fields wrap or extend to the configured state widths.
   assign req_len_m1    = (item.request_length == 8'd0) ? 8'd0 : item.request_length - 8'd1;
   assign req_len_wide  = 32'(req_len_m1);
   assign resp_len_wide = 32'(item.response_length);
   assign timeout_wide  = 32'(item.timeout_ticks);
   assign remaining_dec = remaining_ff - LENGTH_BITS'(1);

   always_comb begin
      phase_in     = phase_ff;
      remaining_in = remaining_ff;
      ticks_in     = ticks_ff;
      resp_len_in  = resp_len_ff;
      timeout_in   = timeout_ff;
      exp_bit_in   = exp_bit_ff;
      finish       = 1'b0;
      err          = ERR_NONE;
      result       = '0;

      case (action_type'(item.action))
         ACT_START: begin
            if (phase_ff == PHASE_IDLE) begin
               result.start_accepted = 1'b1;
               phase_in              = PHASE_SEND;
               remaining_in          = req_len_wide[LENGTH_BITS-1:0];
               resp_len_in           = resp_len_wide[LENGTH_BITS-1:0];
               timeout_in            = timeout_wide[TIMEOUT_BITS-1:0];
               exp_bit_in            = item.expected_ninth_bit;
               result.tx_valid       = 1'b1;
               result.tx_word        = {1'b0, item.data_word[7:0]}
                                       | (item.set_ninth_bit ? NINTH_BIT_MASK : 9'd0);
            end
         end
         ACT_TX_EMPTY, ACT_TX_DONE: begin
            if (phase_ff == PHASE_SEND) begin
               if (remaining_ff != '0) begin
                  result.tx_valid = 1'b1;
                  result.tx_word  = {1'b0, item.data_word[7:0]};
                  remaining_in    = remaining_dec;
               end else if (action_type'(item.action) == ACT_TX_DONE) begin
                  if (resp_len_ff != '0) begin
                     phase_in     = PHASE_RECV;
                     remaining_in = resp_len_ff;
                     ticks_in     = timeout_ff;
                  end else begin
                     finish = 1'b1;
                  end
               end
            end
         end
         ACT_RX_BYTE: begin
            if (phase_ff == PHASE_RECV) begin
               if (item.data_word[8] != exp_bit_ff) begin
                  finish = 1'b1;
                  err    = ERR_SYNC;
               end else begin
                  result.rx_valid = 1'b1;
                  result.rx_byte  = item.data_word[7:0];
                  remaining_in    = remaining_dec;
                  finish          = (remaining_dec == '0);
               end
            end
         end
         ACT_OVERRUN: begin
            if (phase_ff == PHASE_RECV) begin
               finish = 1'b1;
               err    = ERR_OVERRUN;
            end
         end
         ACT_TICK: begin
            if (phase_ff == PHASE_RECV) begin
               if (ticks_ff != '0) begin
                  ticks_in = ticks_ff - TIMEOUT_BITS'(1);
               end else begin
                  finish = 1'b1;
                  err    = ERR_TIMEOUT;
               end
            end
         end
         ACT_ABORT: begin
            if (phase_ff != PHASE_IDLE) begin
               finish = 1'b1;
               err    = ERR_ABORT;
            end
         end
         default: begin
         end
      endcase

      if (finish) begin
         phase_in          = PHASE_IDLE;
         result.done_res   = 1'b1;
         result.error_code = err;
      end
      result.busy_res     = (phase_in != PHASE_IDLE);
      result.drive_enable = (phase_in == PHASE_SEND);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         remaining_ff <= '0;
         ticks_ff     <= '0;
         resp_len_ff  <= '0;
         timeout_ff   <= '0;
         exp_bit_ff   <= 1'b0;
      end else if (step) begin
         phase_ff     <= phase_in;
         remaining_ff <= remaining_in;
         ticks_ff     <= ticks_in;
         resp_len_ff  <= resp_len_in;
         timeout_ff   <= timeout_in;
         exp_bit_ff   <= exp_bit_in;
      end
   end

endmodule

// File: rtl/rs485_ninebit_master_transaction.sv
// Top level of the RS485 nine-bit multidrop master transaction sequencer.
//
// Every line event (start, tx buffer empty, tx complete, byte received, overrun,
// tick, abort) enters as one transfer on the req_chan channel and produces exactly
// one transfer on the rsp_chan channel, in the same order.
// The request is captured in an input register, the transaction state is updated
// by one pass of combinational logic, and the result lands in an output register.
// A result appears on rsp_chan once its request has moved from the input register
// into the output register, and one event is accepted in every cycle while the
// response side keeps up.
// Throughput is set by the single state update per event in the sequencer.
// When the receiver stalls, the output register holds its result and the input
// register can still take one more event; after that req_chan.ready drops until
// the pending result is taken. Nothing is dropped or repeated.
// Reset is synchronous and active high: the block returns to idle with all
// counters and saved start settings cleared and both pipeline registers empty.
module rs485_ninebit_master_transaction #(
   parameter int LENGTH_BITS  = rs485m_pkg::LENGTH_BITS_DEF,
   parameter int TIMEOUT_BITS = rs485m_pkg::TIMEOUT_BITS_DEF
) (
   input logic         clock,
   input logic         reset,
   rs485m_req_if.sink  req_chan,
   rs485m_rsp_if.source rsp_chan
);
   import rs485m_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type seq_result;
   logic    advance;
   logic    req_take;

   // The pipeline moves forward whenever the output register is free or drained.
   assign advance  = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take = req_chan.valid && req_chan.ready;

   assign in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   // State advances only when a captured event moves into the output register.
   rs485m_seq #(
      .LENGTH_BITS (LENGTH_BITS),
      .TIMEOUT_BITS(TIMEOUT_BITS)
   ) u_seq (
      .clock (clock),
      .reset (reset),
      .step  (advance && in_valid_ff),
      .item  (in_item_ff),
      .result(seq_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_chan.payload;
      end
      if (advance && in_valid_ff) begin
         out_item_ff <= seq_result;
      end
   end

   assign rsp_chan.valid   = out_valid_ff;
   assign rsp_chan.payload = out_item_ff;

endmodule
